>>> rtl/xcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared types and constants of the XOR checksum packet deframer.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  localparam logic FuncRx   = 1'b0;
  localparam logic FuncRead = 1'b1;

  localparam logic [7:0] HeaderReset = 8'hAA;

  typedef enum logic [1:0] {
    StNone = 2'd0,
    StGood = 2'd1,
    StBad  = 2'd2,
    StOver = 2'd3
  } status_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } out_item_t;

  // frame report of one received byte
  typedef struct packed {
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } frame_res_t;

  // payload store write request
  typedef struct packed {
    logic       we;
    logic [7:0] pos;
    logic [7:0] data;
  } wr_req_t;

endpackage

>>> rtl/xcpd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpd_store
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xcpd_store #(
  parameter int unsigned PayloadDepth = 64
) (
  input  logic              clk_i,
  input  xcpd_pkg::wr_req_t wr_i,
  input  logic              rd_en_i,
  input  logic [7:0]        rd_index_i,
  output logic [7:0]        rd_data_o
);

  localparam int unsigned AddrW = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;

  logic [7:0] mem [PayloadDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.pos[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_index_i[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/xcpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpd_ctrl
// Frame parser: header hunt, type, length, payload, checksum check.
// ----------------------------------------------------------------------------
module xcpd_ctrl #(
  parameter int unsigned PayloadDepth = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 rx_valid_i,
  input  logic [7:0]           rx_byte_i,
  output xcpd_pkg::wr_req_t    wr_o,
  output xcpd_pkg::frame_res_t res_o
);

  localparam logic [8:0] DepthW = 9'(PayloadDepth);

  typedef enum logic [2:0] {
    PhHeader,
    PhType,
    PhLen,
    PhData,
    PhCheck
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] header_q, header_d;
  logic [7:0] type_q, type_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic       ovf_q, ovf_d;

  always_comb begin
    phase_d  = phase_q;
    header_d = cfg_we_i ? cfg_wdata_i : header_q;
    type_d   = type_q;
    len_d    = len_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    ovf_d    = ovf_q;
    wr_o     = '0;
    wr_o.pos  = pos_q;
    wr_o.data = rx_byte_i;
    res_o    = '0;
    if (rx_valid_i) begin
      case (phase_q)
        PhHeader: begin
          if (rx_byte_i == header_q) begin
            xor_d   = '0;
            ovf_d   = 1'b0;
            phase_d = PhType;
          end
        end
        PhType: begin
          type_d  = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = rx_byte_i;
          pos_d   = '0;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = (rx_byte_i != 8'd0) ? PhData : PhCheck;
        end
        PhData: begin
          if ({1'b0, pos_q} < DepthW) begin
            wr_o.we = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          xor_d = xor_q ^ rx_byte_i;
          if (({1'b0, pos_q} + 9'd1) >= {1'b0, len_q}) begin
            phase_d = PhCheck;
          end
          pos_d = pos_q + 8'd1;
        end
        PhCheck: begin
          res_o.frame_done = 1'b1;
          if (ovf_q) begin
            res_o.frame_status = xcpd_pkg::StOver;
          end else if (rx_byte_i == xor_q) begin
            res_o.frame_status = xcpd_pkg::StGood;
          end else begin
            res_o.frame_status = xcpd_pkg::StBad;
          end
          res_o.frame_type   = type_q;
          res_o.frame_length = len_q;
          phase_d = PhHeader;
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      header_q <= xcpd_pkg::HeaderReset;
      type_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      xor_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      header_q <= header_d;
      type_q   <= type_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      xor_q    <= xor_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

>>> rtl/xor_checksum_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checksum_packet_deframer_unit
// Header/type/length/payload/XOR-checksum deframer with payload buffer.
// ----------------------------------------------------------------------------
// One transaction per cycle is taken in while in_ready_o is high, received
// bytes and buffer reads alike, and each gives one result. The frame
// parser updates its registers in the accept cycle and writes payload bytes
// into the buffer memory at that edge; a read transaction addresses the
// memory at its accept edge and the registered read data forms the first
// result stage, followed by the output register, so one result may wait on
// the output while the next transaction is accepted. The buffer needs no
// clearing after reset; only indices below the reported length are to be
// read, and indices at or above PAYLOAD_DEPTH return zero.
module xor_checksum_packet_deframer_unit #(
  parameter int unsigned PAYLOAD_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xcpd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xcpd_pkg::out_item_t out_data_o
);

  localparam logic [8:0] DepthW = 9'(PAYLOAD_DEPTH);

  logic                 in_acc;
  logic                 rx_acc;
  logic                 rd_acc;
  logic                 rd_in_range;
  logic                 s1_adv;
  logic [7:0]           rd_data;
  xcpd_pkg::wr_req_t    wr_req;
  xcpd_pkg::frame_res_t frame_res;

  logic                 s1_valid_q;
  xcpd_pkg::frame_res_t s1_res_q;
  logic                 s1_rd_q;
  logic                 out_valid_q;
  xcpd_pkg::out_item_t  out_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign rx_acc      = in_acc && (in_data_i.func == xcpd_pkg::FuncRx);
  assign rd_in_range = {3'b000, in_data_i.read_index} < DepthW;
  assign rd_acc      = in_acc && (in_data_i.func == xcpd_pkg::FuncRead) && rd_in_range;

  xcpd_ctrl #(
    .PayloadDepth (PAYLOAD_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_acc),
    .rx_byte_i   (in_data_i.rx_byte),
    .wr_o        (wr_req),
    .res_o       (frame_res)
  );

  xcpd_store #(
    .PayloadDepth (PAYLOAD_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (wr_req),
    .rd_en_i    (rd_acc),
    .rd_index_i ({2'b00, in_data_i.read_index}),
    .rd_data_o  (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= frame_res;
      s1_rd_q  <= rd_acc;
    end
    if (s1_adv) begin
      out_q.frame_done   <= s1_res_q.frame_done;
      out_q.frame_status <= s1_res_q.frame_status;
      out_q.frame_type   <= s1_res_q.frame_type;
      out_q.frame_length <= s1_res_q.frame_length;
      out_q.read_data    <= s1_rd_q ? rd_data : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
